// ----- hdl/tbeq_pkg.sv -----
`timescale 1ns / 1ps

package tbeq_pkg;

  // Sample and coefficient formats: samples Q1.(SAMPLE_BITS-1), coefficients Q4.(COEF_BITS-4).
  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 32;
  localparam int COEF_FRAC   = COEF_BITS - 4;

  // Output gain is unsigned Q2.16 and the smoothing factor unsigned Q0.16.
  localparam int GAIN_BITS   = 18;
  localparam int GAIN_FRAC   = 16;
  localparam int SMOOTH_BITS = 16;

  localparam logic [GAIN_BITS-1:0]   GAIN_RESET   = GAIN_BITS'(1 << GAIN_FRAC);
  localparam logic [SMOOTH_BITS-1:0] SMOOTH_RESET = SMOOTH_BITS'(136);

  // One shared multiplier serves both the coefficients and the unsigned gain.
  localparam int MUL_A_BITS = (COEF_BITS > GAIN_BITS) ? COEF_BITS : GAIN_BITS + 1;
  localparam int PROD_BITS  = MUL_A_BITS + SAMPLE_BITS;
  // Five products are summed, so three guard bits keep the sum exact.
  localparam int ACC_BITS   = PROD_BITS + 3;

  localparam int NUM_SECT       = 3;
  localparam int TAPS           = 5;
  localparam int NUM_SLOTS      = NUM_SECT * TAPS;
  localparam int SLOT_BITS      = $clog2(NUM_SLOTS + 1);
  localparam int SEC_BITS       = $clog2(NUM_SECT);
  localparam int TAP_ADDR_BITS  = 2;
  localparam int NUM_HIST       = NUM_SECT * 4;
  localparam int HIST_ADDR_BITS = SEC_BITS + TAP_ADDR_BITS;
  localparam int PH_BITS        = 3;

  localparam int IN_DATA_BITS  = ((SAMPLE_BITS + SLOT_BITS + COEF_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = GAIN_BITS;

  localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_TARGET = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_SMOOTH      = 1'b1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_COEF   = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SECT,
    ST_GMUL,
    ST_GOUT
  } tbeq_state_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_SUB
  } acc_op_e;

  typedef struct packed {
    logic    mul_en;
    logic    mul_gain;
    acc_op_e acc_op;
  } mac_ctrl_t;

endpackage

// ----- hdl/tbeq_mac.sv -----
`timescale 1ns / 1ps

module tbeq_mac (
  input  logic                                   clk_i,
  input  tbeq_pkg::mac_ctrl_t                    ctrl_i,
  input  logic signed [tbeq_pkg::COEF_BITS-1:0]   coef_i,
  input  logic        [tbeq_pkg::GAIN_BITS-1:0]   gain_i,
  input  logic signed [tbeq_pkg::SAMPLE_BITS-1:0] samp_i,
  output logic signed [tbeq_pkg::SAMPLE_BITS-1:0] sect_o,
  output logic                                   sect_clip_o,
  output logic signed [tbeq_pkg::SAMPLE_BITS-1:0] gout_o,
  output logic                                   gout_clip_o
);
  import tbeq_pkg::*;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] val;
    logic                          clip;
  } sat_t;

  function automatic sat_t saturate(input logic signed [ACC_BITS-1:0] v);
    sat_t                       r;
    logic signed [ACC_BITS-1:0] hi;
    logic signed [ACC_BITS-1:0] lo;
    hi = ACC_BITS'({1'b0, {(SAMPLE_BITS - 1){1'b1}}});
    lo = ~hi;
    r.clip = 1'b1;
    if (v > hi) begin
      r.val = hi[SAMPLE_BITS-1:0];
    end else if (v < lo) begin
      r.val = lo[SAMPLE_BITS-1:0];
    end else begin
      r.val  = v[SAMPLE_BITS-1:0];
      r.clip = 1'b0;
    end
    return r;
  endfunction

  logic signed [MUL_A_BITS-1:0] mul_a;
  logic signed [PROD_BITS-1:0]  prod_q;
  logic signed [ACC_BITS-1:0]   prod_ext;
  logic signed [ACC_BITS-1:0]   acc_q;
  logic signed [ACC_BITS-1:0]   sect_sum;
  logic signed [ACC_BITS-1:0]   sect_shift;
  logic signed [ACC_BITS-1:0]   gout_shift;
  sat_t                         sect_sat;
  sat_t                         gout_sat;

  assign mul_a = ctrl_i.mul_gain ? MUL_A_BITS'(signed'({1'b0, gain_i})) : MUL_A_BITS'(coef_i);
  assign prod_ext = ACC_BITS'(prod_q);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= PROD_BITS'(mul_a) * PROD_BITS'(samp_i);
    end
    case (ctrl_i.acc_op)
      ACC_LOAD: acc_q <= prod_ext;
      ACC_ADD:  acc_q <= acc_q + prod_ext;
      ACC_SUB:  acc_q <= acc_q - prod_ext;
      default:  acc_q <= acc_q;
    endcase
  end

  // The last feedback term is folded in on the fly, so the section result is ready
  // in the cycle after its final product.
  assign sect_sum   = acc_q - prod_ext;
  assign sect_shift = sect_sum >>> COEF_FRAC;
  assign gout_shift = prod_ext >>> GAIN_FRAC;

  assign sect_sat    = saturate(sect_shift);
  assign gout_sat    = saturate(gout_shift);
  assign sect_o      = sect_sat.val;
  assign sect_clip_o = sect_sat.clip;
  assign gout_o      = gout_sat.val;
  assign gout_clip_o = gout_sat.clip;

endmodule

// ----- hdl/three_band_biquad_tone_eq.sv -----
`timescale 1ns / 1ps

// Three-band tone equaliser: every audio sample runs through a treble shelf, a mid peak and
// a bass shelf, each a direct-form-I biquad, and is then scaled by an output gain that glides
// one smoothing step per sample towards its target. Samples are Q1.23, coefficients Q4.28,
// and every section output as well as the final output saturates; tuser on the result is set
// when any of these saturated. Coefficients are loaded through the input stream itself with
// tuser high, one transfer per cycle while no sample is being processed, and without a
// result; after reset each section passes its input straight through. A sample holds off
// the next input transfer until its work is done: the fifteen multiply-accumulates and the
// gain product share one multiplier fed from coefficient and history memories with one read
// port each, in a start-up phase, the phases of each section, the gain product and the load. The
// result sits in an output register, so the next item is accepted while it waits; the
// block stalls only when a second result is ready before the first has been taken.
// Configuration writes are taken in any cycle but should be issued while the block is idle.
module three_band_biquad_tone_eq (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // tdata from bit 0: sample_in[23:0], coef_index[27:24], coef_value[59:28], zero padding.
  input  logic [tbeq_pkg::IN_DATA_BITS-1:0]   s_axis_tdata,
  // tuser: kind (0 audio sample, 1 coefficient write).
  input  logic                                s_axis_tuser,
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // tdata from bit 0: sample_out[23:0].
  output logic [tbeq_pkg::OUT_DATA_BITS-1:0]  m_axis_tdata,
  // tuser: clipped.
  output logic                                m_axis_tuser,
  // Configuration write port.
  input  logic                                cfg_we_i,
  input  logic [tbeq_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [tbeq_pkg::CFG_DATA_BITS-1:0]  cfg_data_i
);
  import tbeq_pkg::*;

  // Phases of one section. The end phase of one section doubles as the issue phase of the
  // next, so only the first section spends a phase of its own on issue.
  localparam logic [PH_BITS-1:0] PH_ISSUE  = 3'd0;
  localparam logic [PH_BITS-1:0] PH_MUL_X  = 3'd1;
  localparam logic [PH_BITS-1:0] PH_MUL_X1 = 3'd2;
  localparam logic [PH_BITS-1:0] PH_MUL_X2 = 3'd3;
  localparam logic [PH_BITS-1:0] PH_MUL_Y1 = 3'd4;
  localparam logic [PH_BITS-1:0] PH_MUL_Y2 = 3'd5;
  localparam logic [PH_BITS-1:0] PH_END    = 3'd6;

  // History layout within a section.
  localparam logic [TAP_ADDR_BITS-1:0] HT_X1 = 2'd0;
  localparam logic [TAP_ADDR_BITS-1:0] HT_X2 = 2'd1;
  localparam logic [TAP_ADDR_BITS-1:0] HT_Y1 = 2'd2;
  localparam logic [TAP_ADDR_BITS-1:0] HT_Y2 = 2'd3;

  localparam logic [SEC_BITS-1:0]  SEC_LAST = SEC_BITS'(NUM_SECT - 1);
  localparam logic [SLOT_BITS-1:0] TAPS_S   = SLOT_BITS'(TAPS);
  localparam logic [SLOT_BITS-1:0] SLOT_END = SLOT_BITS'(NUM_SLOTS);
  localparam logic signed [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC;

  localparam int GS_BITS = SMOOTH_BITS + GAIN_BITS + 3;
  localparam logic signed [GS_BITS-1:0] GS_HALF = GS_BITS'(1) << (GAIN_FRAC - 1);

  // Input fields.
  logic signed [SAMPLE_BITS-1:0] in_sample;
  logic        [SLOT_BITS-1:0]   in_slot;
  logic signed [COEF_BITS-1:0]   in_coef;
  logic                          in_xfer;
  logic                          in_smp;
  logic                          coef_we;

  assign in_sample = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_slot   = s_axis_tdata[SAMPLE_BITS +: SLOT_BITS];
  assign in_coef   = s_axis_tdata[SAMPLE_BITS + SLOT_BITS +: COEF_BITS];
  assign in_xfer   = s_axis_tvalid && s_axis_tready;
  assign in_smp    = in_xfer && (s_axis_tuser == KIND_SAMPLE);
  assign coef_we   = in_xfer && (s_axis_tuser == KIND_COEF) && (in_slot < SLOT_END);

  // Configuration registers.
  logic [GAIN_BITS-1:0]   target_q;
  logic [SMOOTH_BITS-1:0] smooth_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= GAIN_RESET;
      smooth_q <= SMOOTH_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_GAIN_TARGET: target_q <= cfg_data_i[GAIN_BITS-1:0];
        REG_SMOOTH:      smooth_q <= cfg_data_i[SMOOTH_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer signals.
  tbeq_state_e                state_q, state_d;
  logic [SEC_BITS-1:0]        sec_q, sec_d;
  logic [PH_BITS-1:0]         ph_q, ph_d;
  logic                       coef_re;
  logic [SEC_BITS-1:0]        coef_rsec;
  logic [PH_BITS-1:0]         coef_rtap;
  logic [SLOT_BITS-1:0]       coef_rslot;
  logic                       hist_re;
  logic [TAP_ADDR_BITS-1:0]   hist_rtap;
  logic                       hist_we;
  logic [TAP_ADDR_BITS-1:0]   hist_wtap;
  logic signed [SAMPLE_BITS-1:0] hist_wdata;
  mac_ctrl_t                  mac_ctrl;
  logic                       samp_hist;
  logic                       sect_done;
  logic                       gain_upd;
  logic                       out_load;
  logic                       out_free;

  // Datapath signals.
  logic signed [SAMPLE_BITS-1:0] x_q;
  logic signed [SAMPLE_BITS-1:0] x1_q;
  logic signed [SAMPLE_BITS-1:0] y1_q;
  logic signed [SAMPLE_BITS-1:0] sect_val;
  logic                          sect_clip;
  logic signed [SAMPLE_BITS-1:0] gout_val;
  logic                          gout_clip;
  logic                          clip_q;
  logic signed [SAMPLE_BITS-1:0] mac_samp;
  logic [GAIN_BITS-1:0]          gain_q;

  assign out_free   = !m_axis_tvalid || m_axis_tready;
  assign coef_rslot = SLOT_BITS'(coef_rsec) * TAPS_S + SLOT_BITS'(coef_rtap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sec_q   <= '0;
      ph_q    <= PH_ISSUE;
    end else begin
      state_q <= state_d;
      sec_q   <= sec_d;
      ph_q    <= ph_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    sec_d      = sec_q;
    ph_d       = ph_q;
    coef_re    = 1'b0;
    coef_rsec  = sec_q;
    coef_rtap  = ph_q;
    hist_re    = 1'b0;
    hist_rtap  = HT_X1;
    hist_we    = 1'b0;
    hist_wtap  = HT_X1;
    hist_wdata = x_q;
    mac_ctrl   = '{mul_en: 1'b0, mul_gain: 1'b0, acc_op: ACC_HOLD};
    samp_hist  = 1'b0;
    sect_done  = 1'b0;
    gain_upd   = 1'b0;
    out_load   = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_smp) begin
          state_d = ST_SECT;
          sec_d   = '0;
          ph_d    = PH_ISSUE;
        end
      end
      ST_SECT: begin
        ph_d = ph_q + 1'b1;
        // Coefficient k of the section is fetched in phase k and used in phase k+1.
        if (ph_q <= PH_MUL_Y1) begin
          coef_re = 1'b1;
        end
        case (ph_q)
          PH_ISSUE: begin
            // Only the first section starts here; the gain step is taken once per sample.
            gain_upd = 1'b1;
          end
          PH_MUL_X: begin
            mac_ctrl.mul_en = 1'b1;
            hist_re         = 1'b1;
            hist_rtap       = HT_X1;
          end
          PH_MUL_X1: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = ACC_LOAD;
            samp_hist       = 1'b1;
            hist_re         = 1'b1;
            hist_rtap       = HT_X2;
          end
          PH_MUL_X2: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = ACC_ADD;
            samp_hist       = 1'b1;
            hist_re         = 1'b1;
            hist_rtap       = HT_Y1;
            hist_we         = 1'b1;
            hist_wtap       = HT_X2;
            hist_wdata      = x1_q;
          end
          PH_MUL_Y1: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = ACC_ADD;
            samp_hist       = 1'b1;
            hist_re         = 1'b1;
            hist_rtap       = HT_Y2;
            hist_we         = 1'b1;
            hist_wtap       = HT_X1;
            hist_wdata      = x_q;
          end
          PH_MUL_Y2: begin
            mac_ctrl.mul_en = 1'b1;
            mac_ctrl.acc_op = ACC_SUB;
            samp_hist       = 1'b1;
            hist_we         = 1'b1;
            hist_wtap       = HT_Y2;
            hist_wdata      = y1_q;
          end
          PH_END: begin
            hist_we    = 1'b1;
            hist_wtap  = HT_Y1;
            hist_wdata = sect_val;
            sect_done  = 1'b1;
            if (sec_q == SEC_LAST) begin
              state_d = ST_GMUL;
            end else begin
              sec_d     = sec_q + 1'b1;
              ph_d      = PH_MUL_X;
              coef_re   = 1'b1;
              coef_rsec = sec_q + 1'b1;
              coef_rtap = PH_ISSUE;
            end
          end
          default: ;
        endcase
      end
      ST_GMUL: begin
        mac_ctrl.mul_en   = 1'b1;
        mac_ctrl.mul_gain = 1'b1;
        state_d           = ST_GOUT;
      end
      ST_GOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Coefficient memory. Entries never written read as their reset value: one for b0,
  // zero for the rest.
  logic signed [COEF_BITS-1:0] coef_mem [NUM_SLOTS];
  logic signed [COEF_BITS-1:0] coef_rdata_q;
  logic [NUM_SLOTS-1:0]        coef_vld_q;
  logic                        coef_rv_q;
  logic                        coef_rb0_q;
  logic signed [COEF_BITS-1:0] coef_rd;

  always_ff @(posedge clk_i) begin
    if (coef_we) begin
      coef_mem[in_slot] <= in_coef;
    end
    if (coef_re) begin
      coef_rdata_q <= coef_mem[coef_rslot];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_vld_q <= '0;
      coef_rv_q  <= 1'b0;
      coef_rb0_q <= 1'b0;
    end else begin
      if (coef_we) begin
        coef_vld_q[in_slot] <= 1'b1;
      end
      if (coef_re) begin
        coef_rv_q  <= coef_vld_q[coef_rslot];
        coef_rb0_q <= (coef_rtap == PH_ISSUE);
      end
    end
  end

  assign coef_rd = coef_rv_q ? coef_rdata_q : (coef_rb0_q ? COEF_ONE : '0);

  // Section history memory: x[n-1], x[n-2], y[n-1], y[n-2] per section, cleared by reset.
  // Each entry is rewritten only after its read in the same section, so the read-first
  // behaviour of the memory keeps the old value where it is needed.
  logic signed [SAMPLE_BITS-1:0] hist_mem [NUM_HIST];
  logic signed [SAMPLE_BITS-1:0] hist_rdata_q;
  logic [NUM_HIST-1:0]           hist_vld_q;
  logic                          hist_rv_q;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic [HIST_ADDR_BITS-1:0]     hist_raddr;
  logic [HIST_ADDR_BITS-1:0]     hist_waddr;

  assign hist_raddr = {sec_q, hist_rtap};
  assign hist_waddr = {sec_q, hist_wtap};

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_waddr] <= hist_wdata;
    end
    if (hist_re) begin
      hist_rdata_q <= hist_mem[hist_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_vld_q <= '0;
      hist_rv_q  <= 1'b0;
    end else begin
      if (hist_we) begin
        hist_vld_q[hist_waddr] <= 1'b1;
      end
      if (hist_re) begin
        hist_rv_q <= hist_vld_q[hist_raddr];
      end
    end
  end

  assign hist_rd = hist_rv_q ? hist_rdata_q : '0;

  // Section input and the history values that move one slot down.
  always_ff @(posedge clk_i) begin
    if (in_smp) begin
      x_q <= in_sample;
    end else if (sect_done) begin
      x_q <= sect_val;
    end
    if (state_q == ST_SECT && ph_q == PH_MUL_X1) begin
      x1_q <= hist_rd;
    end
    if (state_q == ST_SECT && ph_q == PH_MUL_Y1) begin
      y1_q <= hist_rd;
    end
  end

  assign mac_samp = samp_hist ? hist_rd : x_q;

  tbeq_mac u_mac (
    .clk_i       (clk_i),
    .ctrl_i      (mac_ctrl),
    .coef_i      (coef_rd),
    .gain_i      (gain_q),
    .samp_i      (mac_samp),
    .sect_o      (sect_val),
    .sect_clip_o (sect_clip),
    .gout_o      (gout_val),
    .gout_clip_o (gout_clip)
  );

  // Gain smoothing: the step is the smoothing factor times the distance to the target,
  // rounded half up, and at least one unit while the target has not been reached.
  logic [GAIN_BITS-1:0]          gain_d;
  logic signed [GAIN_BITS:0]     gain_diff;
  logic signed [GS_BITS-1:0]     gain_prod;
  logic signed [GS_BITS-1:0]     gain_step_raw;
  logic signed [GS_BITS-1:0]     gain_step;
  logic signed [GS_BITS-1:0]     gain_sum;

  assign gain_diff     = signed'({1'b0, target_q}) - signed'({1'b0, gain_q});
  assign gain_prod     = GS_BITS'(signed'({1'b0, smooth_q})) * GS_BITS'(gain_diff);
  assign gain_step_raw = (gain_prod + GS_HALF) >>> GAIN_FRAC;

  always_comb begin
    gain_step = gain_step_raw;
    if (gain_step_raw == '0 && gain_diff != '0) begin
      gain_step = gain_diff[GAIN_BITS] ? -GS_BITS'(1) : GS_BITS'(1);
    end
  end

  assign gain_sum = GS_BITS'(signed'({1'b0, gain_q})) + gain_step;
  assign gain_d   = gain_sum[GAIN_BITS-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (gain_upd) begin
      gain_q <= gain_d;
    end
  end

  // Saturation flag of the sample in flight.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q <= 1'b0;
    end else if (in_smp) begin
      clip_q <= 1'b0;
    end else if (sect_done) begin
      clip_q <= clip_q | sect_clip;
    end
  end

  // Output register.
  logic                          m_valid_q;
  logic signed [SAMPLE_BITS-1:0] m_data_q;
  logic                          m_clip_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      m_data_q <= gout_val;
      m_clip_q <= clip_q | gout_clip;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_DATA_BITS'(unsigned'(m_data_q));
  assign m_axis_tuser  = m_clip_q;

endmodule

// ----- tb/three_band_biquad_tone_eq_tb.sv -----
`timescale 1ns / 1ps

module three_band_biquad_tone_eq_tb;
  import tbeq_pkg::*;

  // Saturation bounds of the Q1.23 sample format.
  localparam longint SMP_MAX = (longint'(1) <<< (SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;
  // Allowance for any work still in flight once the last expected result has been taken.
  localparam int SETTLE_CYCLES = 40;
  localparam int SEG_ITEMS     = 100;

  // One input item, with the fields at the widths of the block.
  typedef struct {
    logic                          kind;
    logic signed [SAMPLE_BITS-1:0] sample;
    logic [SLOT_BITS-1:0]          slot;
    logic signed [COEF_BITS-1:0]   coef;
  } eq_item_t;

  // One result item.
  typedef struct {
    logic signed [SAMPLE_BITS-1:0] smp;
    logic                          clip;
  } eq_res_t;

  // A row of the directed table; where known is set, the typed result is what the block
  // must return and the predictor only keeps its state in step.
  typedef struct {
    eq_item_t it;
    bit       known;
    eq_res_t  typed;
  } dir_row_t;

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [IN_DATA_BITS-1:0]  s_axis_tdata  = '0;
  logic                     s_axis_tuser  = KIND_SAMPLE;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [OUT_DATA_BITS-1:0] m_axis_tdata;
  logic                     m_axis_tuser;
  logic                     cfg_we_i      = 1'b0;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i   = REG_GAIN_TARGET;
  logic [CFG_DATA_BITS-1:0] cfg_data_i    = '0;

  // Shadow state of the equaliser: coefficient bank, per-section history (x1 x2 y1 y2),
  // the gliding gain and the two configuration registers.
  longint               coef_bank [NUM_SLOTS];
  longint               band_hist [NUM_HIST];
  longint               gain_glide;
  logic [GAIN_BITS-1:0]   gain_target_q;
  logic [SMOOTH_BITS-1:0] smooth_q;

  // Results still owed by the block, oldest first.
  eq_res_t pending_outputs [$];
  eq_res_t head_res;
  int      fault_count  = 0;
  int      src_idle_pct = 10;
  int      snk_idle_pct = 54;

  // Directed stimulus table.
  dir_row_t dir_rows [$];

  three_band_biquad_tone_eq dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Hard stop, far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("TEST FAILED");
    $finish;
  end

  function automatic longint clamp_sample(input longint v, inout bit clip);
    if (v > SMP_MAX) begin
      clip = 1'b1;
      return SMP_MAX;
    end
    if (v < SMP_MIN) begin
      clip = 1'b1;
      return SMP_MIN;
    end
    return v;
  endfunction

  // One direct-form-I biquad. The five products are summed exactly in 64 bits, then the
  // arithmetic shift gives the floor of the Q4.28 scaling before saturation.
  function automatic longint run_band(input int s, input longint x, inout bit clip);
    int     c = s * TAPS;
    int     h = s * 4;
    longint acc;
    longint r;
    acc = coef_bank[c] * x + coef_bank[c+1] * band_hist[h] + coef_bank[c+2] * band_hist[h+1]
        - coef_bank[c+3] * band_hist[h+2] - coef_bank[c+4] * band_hist[h+3];
    r = clamp_sample(acc >>> COEF_FRAC, clip);
    band_hist[h+1] = band_hist[h];
    band_hist[h]   = x;
    band_hist[h+3] = band_hist[h+2];
    band_hist[h+2] = r;
    return r;
  endfunction

  // Applies one accepted item to the shadow state and returns 1 when it yields a result.
  function automatic bit equalise_item(input eq_item_t it, output eq_res_t res);
    longint d;
    longint step;
    longint y;
    bit     clip = 1'b0;
    if (it.kind == KIND_COEF) begin
      // The spare slot index above the bass section is simply dropped.
      if (it.slot < NUM_SLOTS) coef_bank[it.slot] = it.coef;
      return 1'b0;
    end
    // The gain moves one smoothing step towards its target before it is used, and by at
    // least one unit while it is off target, so that it does arrive.
    d    = longint'(gain_target_q) - gain_glide;
    step = (longint'(smooth_q) * d + 32768) >>> 16;
    if (step == 0 && d != 0) step = (d > 0) ? 1 : -1;
    gain_glide += step;
    y = it.sample;
    for (int s = 0; s < NUM_SECT; s++) y = run_band(s, y, clip);
    y = clamp_sample((y * gain_glide) >>> GAIN_FRAC, clip);
    res.smp  = y[SAMPLE_BITS-1:0];
    res.clip = clip;
    return 1'b1;
  endfunction

  function automatic dir_row_t mk_row(input logic kind, input int smp, input int slot,
                                      input int cval, input bit known, input int out_v,
                                      input bit out_c);
    dir_row_t r;
    r.it.kind    = kind;
    r.it.sample  = SAMPLE_BITS'(smp);
    r.it.slot    = SLOT_BITS'(slot);
    r.it.coef    = cval;
    r.known      = known;
    r.typed.smp  = SAMPLE_BITS'(out_v);
    r.typed.clip = out_c;
    return r;
  endfunction

  // Appends one row to the directed table.
  function automatic void add_row(input dir_row_t r);
    dir_rows = {dir_rows, r};
  endfunction

  // Offers one item on the input stream, waits for its transfer and records what the
  // block owes for it. The sender may first hold tvalid low, each cycle with a chance of src_idle_pct percent.
  task automatic feed(input eq_item_t it, input bit known, input eq_res_t typed);
    eq_res_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_BITS'({it.coef, it.slot, it.sample});
    s_axis_tuser  <= it.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (equalise_item(it, res)) pending_outputs = {pending_outputs, (known ? typed : res)};
  endtask

  // Stops offering items and lets the block drain fully.
  task automatic wait_quiet();
    s_axis_tvalid <= 1'b0;
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Writes both registers on consecutive edges, keeping the shadow copies in step.
  task automatic write_config(input int target, input int smooth);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_GAIN_TARGET;
    cfg_data_i  <= CFG_DATA_BITS'(target);
    @(posedge clk_i);
    gain_target_q = GAIN_BITS'(target);
    cfg_index_i <= REG_SMOOTH;
    cfg_data_i  <= CFG_DATA_BITS'(smooth);
    @(posedge clk_i);
    smooth_q = SMOOTH_BITS'(smooth);
    cfg_we_i <= 1'b0;
  endtask

  // Result side: every transfer is compared with the oldest expectation, field by field.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pending_outputs.size() == 0) begin
          $display("%0t: unexpected result, expected none, got sample %0d clipped %0b",
                   $time, $signed(m_axis_tdata[SAMPLE_BITS-1:0]), m_axis_tuser);
          fault_count++;
        end else begin
          head_res = pending_outputs.pop_front();
          if (m_axis_tdata[SAMPLE_BITS-1:0] !== head_res.smp) begin
            $display("%0t: sample_out mismatch, expected %0d, got %0d", $time,
                     head_res.smp, $signed(m_axis_tdata[SAMPLE_BITS-1:0]));
            fault_count++;
          end
          if (m_axis_tuser !== head_res.clip) begin
            $display("%0t: clipped mismatch, expected %0b, got %0b", $time,
                     head_res.clip, m_axis_tuser);
            fault_count++;
          end
        end
      end
      m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    eq_item_t it;
    eq_res_t  none;
    int       seg_target [6];
    int       seg_smooth [6];
    int       placed;
    int       sec;
    int       pick;
    int       lim;

    // Shadow state after reset: every section passes its input straight through.
    for (int i = 0; i < NUM_SLOTS; i++) coef_bank[i] = (i % TAPS == 0) ? (64'sd1 <<< COEF_FRAC) : 0;
    for (int i = 0; i < NUM_HIST; i++) band_hist[i] = 0;
    gain_glide    = GAIN_RESET;
    gain_target_q = GAIN_RESET;
    smooth_q      = SMOOTH_RESET;
    none.smp      = '0;
    none.clip     = 1'b0;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at reset settings. Pass-through sections and unity gain make the
    // first results plain copies of the input; a treble b0 at either coefficient extreme
    // drives the first section into saturation.
    add_row(mk_row(KIND_SAMPLE, 0, 0, 0, 1, 0, 0));
    add_row(mk_row(KIND_SAMPLE, 8388607, 15, -1, 1, 8388607, 0));
    add_row(mk_row(KIND_SAMPLE, -8388608, 0, 0, 1, -8388608, 0));
    add_row(mk_row(KIND_SAMPLE, -1, 0, 0, 1, -1, 0));
    add_row(mk_row(KIND_SAMPLE, 1, 0, 0, 1, 1, 0));
    // A write to the spare slot index is dropped and leaves the sections untouched.
    add_row(mk_row(KIND_COEF, 0, 15, 32'h7FFF_FFFF, 0, 0, 0));
    add_row(mk_row(KIND_SAMPLE, 4660, 0, 0, 1, 4660, 0));
    add_row(mk_row(KIND_COEF, -1, 0, 32'h7FFF_FFFF, 0, 0, 0));
    add_row(mk_row(KIND_SAMPLE, 8388607, 0, 0, 1, 8388607, 1));
    add_row(mk_row(KIND_SAMPLE, -8388608, 0, 0, 1, -8388608, 1));
    add_row(mk_row(KIND_COEF, 0, 0, 32'h8000_0000, 0, 0, 0));
    add_row(mk_row(KIND_SAMPLE, 8388607, 0, 0, 1, -8388608, 1));
    add_row(mk_row(KIND_SAMPLE, 0, 0, 0, 1, 0, 0));
    // A small filter: feed-forward taps in every band, feedback taps in mid and bass.
    add_row(mk_row(KIND_COEF, 0, 0, 32'h1000_0000, 0, 0, 0));
    add_row(mk_row(KIND_COEF, 0, 1, 32'h0800_0000, 0, 0, 0));
    add_row(mk_row(KIND_COEF, 0, 7, 32'hF000_0000, 0, 0, 0));
    add_row(mk_row(KIND_COEF, 0, 8, 32'hF800_0000, 0, 0, 0));
    add_row(mk_row(KIND_COEF, 0, 14, 32'h0400_0000, 0, 0, 0));
    add_row(mk_row(KIND_SAMPLE, 1000000, 0, 0, 0, 0, 0));
    add_row(mk_row(KIND_SAMPLE, -3000000, 0, 0, 0, 0, 0));
    add_row(mk_row(KIND_SAMPLE, 8388607, 0, 0, 0, 0, 0));
    add_row(mk_row(KIND_SAMPLE, 5, 0, 0, 0, 0, 0));
    add_row(mk_row(KIND_SAMPLE, -8388608, 0, 0, 0, 0, 0));
    foreach (dir_rows[i]) feed(dir_rows[i].it, dir_rows[i].known, dir_rows[i].typed);

    // Random part in six segments, each with its own gain setting: a fast glide to the top of
    // the gain range, a slow and a fast one to zero, a mid value, a random one and unity.
    seg_target = '{262143, 0, 0, 40000, 0, 65536};
    seg_smooth = '{65535, 0, 65535, 136, 0, 1000};
    seg_target[4] = $urandom_range(262143);
    seg_smooth[4] = $urandom_range(65535);

    for (int seg = 0; seg < 6; seg++) begin
      wait_quiet();
      write_config(seg_target[seg], seg_smooth[seg]);
      src_idle_pct = (seg < 2) ? 10 : (seg < 4) ? 54 : 0;
      snk_idle_pct = (seg < 2) ? 54 : (seg < 4) ? 10 : 0;
      placed = 0;
      while (placed < SEG_ITEMS) begin
        pick = $urandom_range(99);
        it.sample = SAMPLE_BITS'($urandom);
        it.slot   = SLOT_BITS'($urandom);
        it.coef   = $urandom;
        if (pick < 4) begin
          // Reload one whole band with a plausible filter: taps within +-1, a1 within +-2.
          sec = $urandom_range(NUM_SECT - 1);
          it.kind = KIND_COEF;
          for (int k = 0; k < TAPS; k++) begin
            lim       = (k == 3) ? (1 << 29) : (1 << 28);
            it.slot   = SLOT_BITS'(sec * TAPS + k);
            it.coef   = $urandom_range(2 * lim) - lim;
            feed(it, 1'b0, none);
          end
          placed += TAPS;
        end else if (pick < 7) begin
          // A lone write of any 32-bit value to any slot index, the spare one included.
          it.kind = KIND_COEF;
          feed(it, 1'b0, none);
          if (it.slot < NUM_SLOTS) placed++;
        end else begin
          it.kind = KIND_SAMPLE;
          case ($urandom_range(9))
            0:       it.sample = SAMPLE_BITS'(SMP_MAX);
            1:       it.sample = SAMPLE_BITS'(SMP_MIN);
            2, 3:    it.sample = SAMPLE_BITS'($urandom_range(131071) - 65536);
            default: it.sample = SAMPLE_BITS'($urandom);
          endcase
          feed(it, 1'b0, none);
          placed++;
        end
      end
    end

    wait_quiet();
    if (fault_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/tbeq_pkg.sv
hdl/tbeq_mac.sv
hdl/three_band_biquad_tone_eq.sv
tb/three_band_biquad_tone_eq_tb.sv
